>>> src/rrps_pkg.sv
// ----------------------------------------------------------------------------
// rrps_pkg: shared constants and helpers for the round-robin scheduler
// Slot count, command codes, segment constants and the slot-to-segment map.
// ----------------------------------------------------------------------------
package rrps_pkg;

    // Process table size (2 to 8)
    localparam int NUM_PROCS = 8;
    localparam int ID_W      = $clog2(NUM_PROCS);
    localparam int ID_PORT_W = 3;

    localparam logic [15:0] STACK_INIT   = 16'hFF00;
    localparam logic [15:0] USER_SEG_MIN = 16'h2000;

    localparam logic [ID_W-1:0] LAST_ID = ID_W'(NUM_PROCS - 1);

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SPAWN  = 3'd1;
    localparam logic [2:0] CMD_BSPAWN = 3'd2;
    localparam logic [2:0] CMD_TERM   = 3'd3;
    localparam logic [2:0] CMD_KILL   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAKE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Segment of a slot: (id + 2) * 0x1000, kept to 16 bits
    function automatic logic [15:0] seg_of(input logic [ID_W-1:0] id);
        logic [3:0] hi;
        hi = 4'(id) + 4'd2;
        return {hi, 12'h000};
    endfunction

    // Round-robin successor of a slot index
    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] id);
        return (id == LAST_ID) ? '0 : ID_W'(id + 1'b1);
    endfunction

endpackage

>>> src/round_robin_process_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Process slot table with round-robin tick scheduling, spawn, terminate, kill.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears for a single cycle with
// o_done high and must be captured then: there is no way to hold it. One slot
// is examined per cycle by a single compare step under a small sequencer, so a
// command scans at most the whole table between accepting it and the result;
// terminate, and kill of a slot in the table, sweep the whole table to wake
// waiters; a bad kill target or an unsupported command skips to the result.
module round_robin_process_scheduler
    import rrps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_cmd,
    input  logic [15:0]          i_interrupted_segment,
    input  logic [15:0]          i_interrupted_stack,
    input  logic [ID_PORT_W-1:0] i_target_id,
    input  logic                 i_load_ok,
    output logic                 o_done,
    output logic [15:0]          o_resume_segment,
    output logic [15:0]          o_resume_stack,
    output logic [ID_PORT_W-1:0] o_running_id,
    output logic [ID_PORT_W-1:0] o_new_slot,
    output logic                 o_slot_found
);

    t_state r_state, n_state;

    logic [NUM_PROCS-1:0] r_slot_active;
    logic [NUM_PROCS-1:0] r_wait_valid;
    logic [ID_W-1:0]      r_wait_child  [NUM_PROCS];
    logic [15:0]          r_saved_stack [NUM_PROCS];
    logic [ID_W-1:0]      r_cur;

    logic [2:0]      r_cmd;
    logic            r_user;
    logic            r_load_ok;
    logic [ID_W-1:0] r_idx;
    logic [ID_W-1:0] r_child;

    logic [15:0]     r_out_seg;
    logic [15:0]     r_out_sp;
    logic [ID_W-1:0] r_new_slot;
    logic            r_found;

    logic            accept;
    logic            tgt_ok;
    logic [ID_W-1:0] tgt_idx;
    logic            scan_hit;
    logic            scan_end;
    logic            is_last;
    logic            wake_hit;

    assign accept  = start && (r_state == S_IDLE);
    assign tgt_ok  = int'(i_target_id) < NUM_PROCS;
    assign tgt_idx = ID_W'(i_target_id);
    assign is_last = (r_idx == LAST_ID);

    // Shared per-slot compare
    always_comb begin
        case (r_cmd)
            CMD_TICK:   scan_hit = r_slot_active[r_idx] || (r_user && r_idx == r_cur);
            CMD_SPAWN,
            CMD_BSPAWN: scan_hit = !r_slot_active[r_idx] && !r_wait_valid[r_idx];
            default:    scan_hit = 1'b0;
        endcase
        // a user tick always lands on a slot, at worst back on the current one
        scan_end = scan_hit || (!r_user && is_last);
        wake_hit = r_wait_valid[r_idx] && (r_wait_child[r_idx] == r_child);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        CMD_TICK, CMD_SPAWN, CMD_BSPAWN: n_state = S_SCAN;
                        CMD_TERM: n_state = S_WAKE;
                        CMD_KILL: n_state = tgt_ok ? S_WAKE : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN:  if (scan_end) n_state = S_DONE;
            S_WAKE:  if (is_last) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot_active <= '0;
            r_wait_valid  <= '0;
            r_cur         <= '0;
            r_cmd         <= CMD_TICK;
            r_user        <= 1'b0;
            r_idx         <= '0;
            for (int k = 0; k < NUM_PROCS; k++) begin
                r_wait_child[k]  <= '0;
                r_saved_stack[k] <= STACK_INIT;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_cmd;
                        r_load_ok  <= i_load_ok;
                        r_out_seg  <= i_interrupted_segment;
                        r_out_sp   <= i_interrupted_stack;
                        r_new_slot <= '0;
                        r_found    <= 1'b0;
                        r_idx      <= '0;
                        r_user     <= 1'b0;
                        r_child    <= r_cur;
                        case (i_cmd)
                            CMD_TICK: begin
                                if (i_interrupted_segment >= USER_SEG_MIN) begin
                                    r_saved_stack[r_cur] <= i_interrupted_stack;
                                    r_idx  <= next_id(r_cur);
                                    r_user <= 1'b1;
                                end
                            end
                            CMD_TERM: begin
                                r_wait_valid[r_cur]  <= 1'b0;
                                r_slot_active[r_cur] <= 1'b0;
                            end
                            CMD_KILL: begin
                                if (tgt_ok) begin
                                    r_slot_active[tgt_idx] <= 1'b0;
                                    r_child <= tgt_idx;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        if (r_cmd == CMD_TICK) begin
                            r_cur     <= r_idx;
                            r_out_seg <= seg_of(r_idx);
                            r_out_sp  <= r_saved_stack[r_idx];
                        end else begin
                            r_saved_stack[r_idx] <= STACK_INIT;
                            r_wait_valid[r_idx]  <= 1'b0;
                            r_found              <= 1'b1;
                            r_new_slot           <= r_idx;
                            if (r_load_ok) begin
                                // parent goes to sleep first so a self-spawn ends active
                                if (r_cmd == CMD_BSPAWN) begin
                                    r_wait_valid[r_cur]  <= 1'b1;
                                    r_wait_child[r_cur]  <= r_idx;
                                    r_slot_active[r_cur] <= 1'b0;
                                end
                                r_slot_active[r_idx] <= 1'b1;
                            end
                        end
                    end else begin
                        r_idx <= next_id(r_idx);
                    end
                end
                S_WAKE: begin
                    if (wake_hit) begin
                        r_wait_valid[r_idx]  <= 1'b0;
                        r_slot_active[r_idx] <= 1'b1;
                    end
                    r_idx <= next_id(r_idx);
                end
                default: ;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_resume_segment = r_out_seg;
    assign o_resume_stack   = r_out_sp;
    assign o_running_id     = ID_PORT_W'(r_cur);
    assign o_new_slot       = ID_PORT_W'(r_new_slot);
    assign o_slot_found     = r_found;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("scheduler state not one-hot");

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur) < NUM_PROCS)
        else $error("running slot outside table");

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("result beat not followed by idle");

    a_found_only_spawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_slot_found |-> (r_cmd == CMD_SPAWN || r_cmd == CMD_BSPAWN))
        else $error("slot found on a non-spawn command");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

endmodule
